// ===== hw/rtl/complex_arithmetic_unit_assert.svh =====
// ----------------------------------------------------------------------------
// complex arithmetic unit assertion macros
// clocked concurrent checks, disabled while reset is applied
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

`define CAU_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

`define CAU_NEVER(name, cond, msg) \
  `CAU_ASSERT(name, !(cond), msg)

`endif

// ===== hw/rtl/cau_pkg.sv =====
// ----------------------------------------------------------------------------
// cau_pkg
// widths, operation codes and pipeline stage types of the complex unit
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DATA_WIDTH = 32;
  localparam int FRAC_BITS  = 16;
  localparam int PROD_W     = 2 * DATA_WIDTH;
  localparam int REM_W      = PROD_W + 1;

  typedef enum logic [2:0] {
    OP_ADD = 3'd0,
    OP_SUB = 3'd1,
    OP_MUL = 3'd2,
    OP_DIV = 3'd3,
    OP_INC = 3'd4
  } op_e;

  typedef struct packed {
    logic                        valid;
    logic [2:0]                  op;
    logic signed [PROD_W-1:0]    p_ac;
    logic signed [PROD_W-1:0]    p_bd;
    logic signed [PROD_W-1:0]    p_bc;
    logic signed [PROD_W-1:0]    p_ad;
    logic signed [PROD_W-1:0]    p_cc;
    logic signed [PROD_W-1:0]    p_dd;
    logic signed [DATA_WIDTH:0]  sum_re;
    logic signed [DATA_WIDTH:0]  sum_im;
  } mul_stage_t;

  typedef struct packed {
    logic              valid;
    logic [2:0]        op;
    logic              dz;
    logic              neg_re;
    logic              neg_im;
    logic [PROD_W-1:0] mag_re;
    logic [PROD_W-1:0] mag_im;
    logic [PROD_W-1:0] den;
  } sum_stage_t;

  typedef struct packed {
    logic                  valid;
    logic [2:0]            op;
    logic                  dz;
    logic                  neg_re;
    logic                  neg_im;
    logic                  big_re;
    logic                  big_im;
    logic [REM_W-1:0]      rem_re;
    logic [REM_W-1:0]      rem_im;
    logic [DATA_WIDTH-1:0] nlo_re;
    logic [DATA_WIDTH-1:0] nlo_im;
    logic [PROD_W-1:0]     den;
  } div_stage_t;

endpackage

// ===== hw/rtl/cau_if.sv =====
// ----------------------------------------------------------------------------
// cau_if
// operand and result channels with valid/ready handshake
// ----------------------------------------------------------------------------
interface cau_in_if;
  logic                                  valid;
  logic                                  ready;
  logic [2:0]                            operation;
  logic signed [cau_pkg::DATA_WIDTH-1:0] a_re;
  logic signed [cau_pkg::DATA_WIDTH-1:0] a_im;
  logic signed [cau_pkg::DATA_WIDTH-1:0] b_re;
  logic signed [cau_pkg::DATA_WIDTH-1:0] b_im;

  modport source (output valid, operation, a_re, a_im, b_re, b_im, input ready);
  modport sink   (input valid, operation, a_re, a_im, b_re, b_im, output ready);
endinterface

interface cau_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [cau_pkg::DATA_WIDTH-1:0] res_re;
  logic signed [cau_pkg::DATA_WIDTH-1:0] res_im;
  logic                                  divide_by_zero;
  logic                                  overflow;

  modport source (output valid, res_re, res_im, divide_by_zero, overflow, input ready);
  modport sink   (input valid, res_re, res_im, divide_by_zero, overflow, output ready);
endinterface

// ===== hw/rtl/complex_arithmetic_unit.sv =====
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// pipelined complex add, subtract, multiply, divide and increment in Q16.16
// ----------------------------------------------------------------------------
// channel  dir  payload
// in_i     in   operation, a_re, a_im, b_re, b_im
// out_o    out  res_re, res_im, divide_by_zero, overflow
//
// one item per cycle while the output is not stalled; a restoring divider
// computes one quotient bit per stage
// every stage advances together whenever the output register is empty or taken
// reset clears the valid bits only; payload registers are not reset
// ----------------------------------------------------------------------------
`include "complex_arithmetic_unit_assert.svh"

module complex_arithmetic_unit (
  input  logic clk_i,
  input  logic rst_ni,
  cau_in_if.sink    in_i,
  cau_out_if.source out_o
);

  localparam int DW = cau_pkg::DATA_WIDTH;
  localparam int FB = cau_pkg::FRAC_BITS;
  localparam int PW = cau_pkg::PROD_W;
  localparam int RW = cau_pkg::REM_W;
  localparam logic signed [DW:0] IncVal = (DW+1)'(1) << FB;

  logic en;

  cau_pkg::mul_stage_t s1_d, s1_q;
  cau_pkg::sum_stage_t s2_d, s2_q;
  cau_pkg::div_stage_t dv_d [DW+1];
  cau_pkg::div_stage_t dv_q [DW+1];

  logic                 out_valid_q;
  logic signed [DW-1:0] res_re_d, res_re_q, res_im_d, res_im_q;
  logic                 dz_d, dz_q, ovf_d, ovf_q;

  assign en         = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // operand products and short sums
  always_comb begin
    s1_d.valid = in_i.valid;
    s1_d.op    = in_i.operation;
    s1_d.p_ac  = PW'(in_i.a_re) * PW'(in_i.b_re);
    s1_d.p_bd  = PW'(in_i.a_im) * PW'(in_i.b_im);
    s1_d.p_bc  = PW'(in_i.a_im) * PW'(in_i.b_re);
    s1_d.p_ad  = PW'(in_i.a_re) * PW'(in_i.b_im);
    s1_d.p_cc  = PW'(in_i.b_re) * PW'(in_i.b_re);
    s1_d.p_dd  = PW'(in_i.b_im) * PW'(in_i.b_im);
    case (in_i.operation)
      cau_pkg::OP_ADD: begin
        s1_d.sum_re = (DW+1)'(in_i.a_re) + (DW+1)'(in_i.b_re);
        s1_d.sum_im = (DW+1)'(in_i.a_im) + (DW+1)'(in_i.b_im);
      end
      cau_pkg::OP_SUB: begin
        s1_d.sum_re = (DW+1)'(in_i.a_re) - (DW+1)'(in_i.b_re);
        s1_d.sum_im = (DW+1)'(in_i.a_im) - (DW+1)'(in_i.b_im);
      end
      cau_pkg::OP_INC: begin
        s1_d.sum_re = (DW+1)'(in_i.a_re) + IncVal;
        s1_d.sum_im = (DW+1)'(in_i.a_im) + IncVal;
      end
      default: begin
        s1_d.sum_re = '0;
        s1_d.sum_im = '0;
      end
    endcase
  end

  // cross sums, sign and magnitude
  always_comb begin
    logic signed [PW:0] t_re;
    logic signed [PW:0] t_im;
    case (s1_q.op)
      cau_pkg::OP_MUL: begin
        t_re = (PW+1)'(s1_q.p_ac) - (PW+1)'(s1_q.p_bd);
        t_im = (PW+1)'(s1_q.p_bc) + (PW+1)'(s1_q.p_ad);
      end
      cau_pkg::OP_DIV: begin
        t_re = (PW+1)'(s1_q.p_ac) + (PW+1)'(s1_q.p_bd);
        t_im = (PW+1)'(s1_q.p_bc) - (PW+1)'(s1_q.p_ad);
      end
      default: begin
        t_re = (PW+1)'(s1_q.sum_re);
        t_im = (PW+1)'(s1_q.sum_im);
      end
    endcase
    s2_d.valid  = s1_q.valid;
    s2_d.op     = s1_q.op;
    s2_d.neg_re = t_re[PW];
    s2_d.neg_im = t_im[PW];
    s2_d.mag_re = t_re[PW] ? PW'(-t_re) : PW'(t_re);
    s2_d.mag_im = t_im[PW] ? PW'(-t_im) : PW'(t_im);
    s2_d.den    = PW'(unsigned'(s1_q.p_cc)) + PW'(unsigned'(s1_q.p_dd));
    s2_d.dz     = (s1_q.op == cau_pkg::OP_DIV) && (s2_d.den == '0);
  end

  // divider set-up, quotient range check
  always_comb begin
    logic [PW-1:0] hi_re;
    logic [PW-1:0] hi_im;
    hi_re = s2_q.mag_re >> (DW - FB);
    hi_im = s2_q.mag_im >> (DW - FB);
    dv_d[0].valid  = s2_q.valid;
    dv_d[0].op     = s2_q.op;
    dv_d[0].dz     = s2_q.dz;
    dv_d[0].neg_re = s2_q.neg_re;
    dv_d[0].neg_im = s2_q.neg_im;
    dv_d[0].den    = s2_q.den;
    dv_d[0].big_re = 1'b0;
    dv_d[0].big_im = 1'b0;
    dv_d[0].nlo_re = '0;
    dv_d[0].nlo_im = '0;
    case (s2_q.op)
      cau_pkg::OP_DIV: begin
        dv_d[0].big_re = hi_re >= s2_q.den;
        dv_d[0].big_im = hi_im >= s2_q.den;
        dv_d[0].rem_re = RW'(hi_re);
        dv_d[0].rem_im = RW'(hi_im);
        dv_d[0].nlo_re = DW'(s2_q.mag_re) << FB;
        dv_d[0].nlo_im = DW'(s2_q.mag_im) << FB;
      end
      cau_pkg::OP_MUL: begin
        dv_d[0].rem_re = RW'(s2_q.mag_re >> FB);
        dv_d[0].rem_im = RW'(s2_q.mag_im >> FB);
      end
      default: begin
        dv_d[0].rem_re = RW'(s2_q.mag_re);
        dv_d[0].rem_im = RW'(s2_q.mag_im);
      end
    endcase
  end

  // one quotient bit per stage
  for (genvar k = 0; k < DW; k++) begin : g_div
    always_comb begin
      logic [RW-1:0] r_re;
      logic [RW-1:0] r_im;
      logic          ge_re;
      logic          ge_im;
      r_re  = {dv_q[k].rem_re[RW-2:0], dv_q[k].nlo_re[DW-1]};
      r_im  = {dv_q[k].rem_im[RW-2:0], dv_q[k].nlo_im[DW-1]};
      ge_re = r_re >= RW'(dv_q[k].den);
      ge_im = r_im >= RW'(dv_q[k].den);
      dv_d[k+1] = dv_q[k];
      if (dv_q[k].op == cau_pkg::OP_DIV) begin
        dv_d[k+1].rem_re = ge_re ? r_re - RW'(dv_q[k].den) : r_re;
        dv_d[k+1].rem_im = ge_im ? r_im - RW'(dv_q[k].den) : r_im;
        dv_d[k+1].nlo_re = {dv_q[k].nlo_re[DW-2:0], ge_re};
        dv_d[k+1].nlo_im = {dv_q[k].nlo_im[DW-2:0], ge_im};
      end
    end
  end

  function automatic logic [DW:0] sat_part(input logic neg, input logic big,
                                           input logic [RW-1:0] mag);
    logic [RW-1:0] lim;
    logic          ovf;
    logic [DW-1:0] val;
    lim = RW'(1) << (DW - 1);
    ovf = big || (neg ? (mag > lim) : (mag > lim - RW'(1)));
    if (ovf) begin
      val = neg ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      val = neg ? DW'(RW'(0) - mag) : DW'(mag);
    end
    return {ovf, val};
  endfunction

  // saturation and result select
  always_comb begin
    cau_pkg::div_stage_t f;
    logic                is_div;
    logic [DW:0]         sr;
    logic [DW:0]         si;
    f      = dv_q[DW];
    is_div = f.op == cau_pkg::OP_DIV;
    sr = sat_part(f.neg_re, is_div && f.big_re, is_div ? RW'(f.nlo_re) : f.rem_re);
    si = sat_part(f.neg_im, is_div && f.big_im, is_div ? RW'(f.nlo_im) : f.rem_im);
    dz_d = f.dz;
    if (f.dz || (f.op > cau_pkg::OP_INC)) begin
      res_re_d = '0;
      res_im_d = '0;
      ovf_d    = 1'b0;
    end else begin
      res_re_d = sr[DW-1:0];
      res_im_d = si[DW-1:0];
      ovf_d    = sr[DW] || si[DW];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q.valid  <= 1'b0;
      s2_q.valid  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      s1_q        <= s1_d;
      s2_q        <= s2_d;
      out_valid_q <= dv_q[DW].valid;
      res_re_q    <= res_re_d;
      res_im_q    <= res_im_d;
      dz_q        <= dz_d;
      ovf_q       <= ovf_d;
    end
  end

  for (genvar k = 0; k <= DW; k++) begin : g_dv_reg
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_q[k].valid <= 1'b0;
      end else if (en) begin
        dv_q[k] <= dv_d[k];
      end
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.res_re         = res_re_q;
  assign out_o.res_im         = res_im_q;
  assign out_o.divide_by_zero = dz_q;
  assign out_o.overflow       = ovf_q;

  `CAU_ASSERT(a_dz_zero, out_valid_q && dz_q |-> res_re_q == '0 && res_im_q == '0 && !ovf_q, "zero divisor item has nonzero result")
  `CAU_NEVER(a_flags_excl, out_valid_q && dz_q && ovf_q, "divide by zero and overflow together")
  `CAU_ASSERT(a_ready_free, !out_valid_q |-> in_i.ready, "input stalled with empty output")

endmodule
